[rtl/core/wfs_pkg.sv]
// Shared types, constants and helpers of the weigh filter.
`timescale 1ns / 1ps
package wfs_pkg;
    localparam int MOVING_DEPTH  = 16;
    localparam int AVERAGE_DEPTH = 16;
    localparam logic [31:0] JUMP_LIMIT = 32'd50000;
    localparam logic [4:0] WARM_LIMIT  = 5'd15;
    localparam logic [4:0] CAL_STABLE  = 5'd20;
    localparam logic [4:0] NORM_STABLE = 5'd10;
    localparam logic [4:0] COUNT_MAX   = 5'd31;

    localparam logic [2:0] REG_CODE_STEP = 3'd0;
    localparam logic [2:0] REG_CAL_MODE  = 3'd1;
    localparam logic [2:0] REG_LIN_CAL   = 3'd2;
    localparam logic [2:0] REG_USER_CAL  = 3'd3;
    localparam logic [2:0] REG_REPEAT    = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic brk;       // manual break
        logic stage1;    // jump test, moving sums, warm-up
        logic select;    // bypass select, ring write
        logic acc_clr;   // start ring sum
        logic acc_add;   // add one ring entry
        logic div_init;  // load divider
        logic div_step;  // one quotient bit
        logic finish;    // stability update
    } wfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic acc_done;
        logic div_done;
    } wfs_status_t;

    function automatic logic [31:0] distance(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        if (d[31])
            d = 32'd0 - d;
        return d;
    endfunction
endpackage

[rtl/core/weigh_filter_with_stability.sv]
// Top level of the load-cell weigh filter with stability detection.
`timescale 1ns / 1ps
// One beat in, one beat out. A sample beat (action 0) passes a 16-deep moving
// sum scaled by 1/256, a 16-deep moving average and a bypass select, is
// written into an averaging ring, and the ring mean is the filtered value;
// closeness of successive outputs drives the stable flag and track enables.
// A sample goes through an accept step, the jump test and moving sums, the
// bypass select, a sum of the filled ring entries over its single registered
// read port, a divider load, one quotient bit a cycle over 37 bits (at the
// default depth) with a restoring divider, and a finish step. A manual break
// beat (action 1) goes from the accept step straight to the finish step. The
// next beat is accepted once the result has been handed to the output
// register; a waiting result holds the following item only in its finish
// step, so an output stall delays that item only if the stall lasts past
// the point where that item reaches its finish step.
// Configuration writes are taken at any time but are meant for idle periods.
module weigh_filter_with_stability
#(
    parameter int AVERAGE_DEPTH = wfs_pkg::AVERAGE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // raw_sample[31:0]
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // filtered_value[31:0], first_average[63:32], selected_average[95:64],
    // stable[96], zero_track_enable[97], load_track_enable[98], zero pad
    output logic [103:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    wfs_pkg::wfs_cmd_t    cmd;
    wfs_pkg::wfs_status_t status;
    logic [15:0] code_step_reg;
    logic cal_mode_reg, lin_cal_reg, user_cal_reg, repeat_reg;
    logic [31:0] fv, fa, sa;
    logic st;

    // result register: load when cap_reg is set after finish, hold while stalled
    logic [31:0] fv_reg, fa_reg, sa_reg;
    logic st_reg, lt_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_step_reg <= 16'd1;
            cal_mode_reg  <= 1'b0;
            lin_cal_reg   <= 1'b0;
            user_cal_reg  <= 1'b0;
            repeat_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wfs_pkg::REG_CODE_STEP: code_step_reg <= cfg_data;
                wfs_pkg::REG_CAL_MODE:  cal_mode_reg  <= cfg_data[0];
                wfs_pkg::REG_LIN_CAL:   lin_cal_reg   <= cfg_data[0];
                wfs_pkg::REG_USER_CAL:  user_cal_reg  <= cfg_data[0];
                wfs_pkg::REG_REPEAT:    repeat_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    wfs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (s_axis_tvalid && s_axis_tready),
        .in_action (s_axis_tuser),
        .out_fire  (m_axis_tvalid && m_axis_tready),
        .status    (status),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .cmd       (cmd)
    );

    wfs_datapath #(.AVERAGE_DEPTH(AVERAGE_DEPTH)) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .raw_in           (s_axis_tdata),
        .code_step        (code_step_reg),
        .calibration_mode (cal_mode_reg),
        .status           (status),
        .filtered_value   (fv),
        .first_average    (fa),
        .selected_average (sa),
        .stable           (st)
    );

    // datapath values settle in the cycle after finish; cap_reg marks it and the result register captures at its end
    logic cap_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= 1'b0;
        else
            cap_reg <= cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cap_reg)
        begin
            fv_reg <= fv;
            fa_reg <= fa;
            sa_reg <= sa;
            st_reg <= st;
            lt_reg <= st && lin_cal_reg && !user_cal_reg && repeat_reg;
        end
    end

    // bypass the capture register in the settle cycle
    always_comb
    begin
        if (cap_reg)
            m_axis_tdata = {5'd0, st && lin_cal_reg && !user_cal_reg && repeat_reg, st, st,
                            sa, fa, fv};
        else
            m_axis_tdata = {5'd0, lt_reg, st_reg, st_reg, sa_reg, fa_reg, fv_reg};
    end
endmodule

[rtl/core/wfs_ctrl.sv]
// Sequencing state machine of the weigh filter.
`timescale 1ns / 1ps
module wfs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_fire,
    input  logic                 in_action,
    input  logic                 out_fire,
    input  wfs_pkg::wfs_status_t status,
    output logic                 in_ready,
    output logic                 out_valid,
    output wfs_pkg::wfs_cmd_t    cmd
);
    typedef enum logic [2:0] {S_IDLE, S_STAGE, S_SEL, S_ACC, S_DIVI, S_DIV, S_FIN, S_OUT}
        state_t;
    state_t state_reg, state_next;
    logic   brk_reg, brk_next;
    logic   valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        brk_next   = brk_reg;
        valid_next = valid_reg;
        cmd        = '0;
        if (out_fire)
            valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    brk_next   = in_action;
                    state_next = in_action ? S_FIN : S_STAGE;
                end
            end
            S_STAGE:
            begin
                cmd.stage1 = 1'b1;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                cmd.select  = 1'b1;
                cmd.acc_clr = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                if (status.acc_done)
                    state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!valid_next)
                begin
                    cmd.finish = 1'b1;
                    cmd.brk    = brk_reg;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            brk_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            brk_reg   <= brk_next;
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.stage1, cmd.select, cmd.acc_add, cmd.div_step, cmd.finish}))
        else $error("overlapping commands");
    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid) else $error("finish without result");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_fire) else $error("accept while busy");
endmodule

[rtl/core/wfs_datapath.sv]
// Filter datapath: moving sums, averaging ring, divider, stability.
`timescale 1ns / 1ps
module wfs_datapath
#(
    parameter int AVERAGE_DEPTH = wfs_pkg::AVERAGE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  wfs_pkg::wfs_cmd_t    cmd,
    input  logic [31:0]          raw_in,
    input  logic [15:0]          code_step,
    input  logic                 calibration_mode,
    output wfs_pkg::wfs_status_t status,
    output logic [31:0]          filtered_value,
    output logic [31:0]          first_average,
    output logic [31:0]          selected_average,
    output logic                 stable
);
    localparam int AW = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam int CW = $clog2(AVERAGE_DEPTH + 1);
    localparam int SW = 32 + AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(AVERAGE_DEPTH);

    logic [31:0] raw_reg, prev_reg;
    logic [31:0] ring1_reg [16];
    logic [31:0] ring2_reg [16];
    logic [36:0] sum1_reg;
    logic [31:0] sum2_reg;
    logic [3:0]  idx1_reg, idx2_reg;
    logic [4:0]  wa_reg, wb_reg;
    logic [31:0] avg_mem [AVERAGE_DEPTH];
    logic [CW-1:0] aidx_reg, cnt_reg, rd_reg;
    logic        afull_reg;
    logic [31:0] sel_reg, out_reg;
    logic [4:0]  scnt_reg;
    logic        smark_reg;
    logic [SW-1:0] acc_reg;
    logic [31:0] rdata_reg;
    logic        rvalid_reg;
    logic [31:0] quo_reg;
    logic [CW:0] rem_reg;
    logic [5:0]  dcnt_reg;

    logic [31:0] stage_a, stage_b, d_sel;
    logic [35:0] ten_step;
    logic [36:0] sum1_next;
    logic [31:0] sum2_next;
    logic [CW:0] rem_sh;
    logic [CW-1:0] aidx_w;

    assign stage_a   = {3'b000, sum1_reg[36:8]};
    assign sum1_next = sum1_reg + 37'(raw_reg) - 37'(ring1_reg[idx1_reg]);
    assign sum2_next = sum2_reg + {3'b000, sum1_next[36:8]} - ring2_reg[idx2_reg];
    assign stage_b   = sum2_reg >> 4;
    assign ten_step  = 36'(code_step) * 36'd10;
    assign d_sel     = wfs_pkg::distance(out_reg, sel_reg);
    assign aidx_w    = (aidx_reg >= DEPTH_C) ? '0 : aidx_reg;
    assign rem_sh    = {rem_reg[CW-1:0], acc_reg[SW-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            raw_reg <= raw_in;
        if (cmd.select)
            avg_mem[aidx_w[AW-1:0]] <= (wb_reg > wfs_pkg::WARM_LIMIT ||
                                       36'(d_sel) < ten_step) ? stage_b : stage_a;
        rdata_reg <= avg_mem[rd_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0; sum1_reg <= '0; sum2_reg <= '0;
            idx1_reg <= '0; idx2_reg <= '0; wa_reg <= '0; wb_reg <= '0;
            for (int i = 0; i < 16; i++)
            begin
                ring1_reg[i] <= '0;
                ring2_reg[i] <= '0;
            end
            aidx_reg <= '0; afull_reg <= 1'b0; cnt_reg <= '0; rd_reg <= '0;
            sel_reg <= '0; out_reg <= '0; scnt_reg <= '0; smark_reg <= 1'b0;
            acc_reg <= '0; rvalid_reg <= 1'b0; quo_reg <= '0; rem_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.stage1)
            begin
                logic [4:0] wa, wb;
                wa = wa_reg; wb = wb_reg;
                if (wfs_pkg::distance(prev_reg, raw_reg) > wfs_pkg::JUMP_LIMIT)
                begin
                    scnt_reg <= '0; smark_reg <= 1'b0; wa = '0; wb = '0;
                    aidx_reg <= '0; afull_reg <= 1'b0;
                end
                prev_reg <= raw_reg;
                sum1_reg <= sum1_next;
                ring1_reg[idx1_reg] <= raw_reg;
                idx1_reg <= idx1_reg + 4'd1;
                sum2_reg <= sum2_next;
                ring2_reg[idx2_reg] <= {3'b000, sum1_next[36:8]};
                idx2_reg <= idx2_reg + 4'd1;
                if (wa < wfs_pkg::COUNT_MAX)
                    wa = wa + 5'd1;
                if (wa > wfs_pkg::WARM_LIMIT)
                begin
                    if (wb < wfs_pkg::COUNT_MAX)
                        wb = wb + 5'd1;
                end
                else
                    wb = '0;
                wa_reg <= wa; wb_reg <= wb;
            end
            if (cmd.select)
            begin
                // write index happens in the memory block; advance here
                sel_reg <= (wb_reg > wfs_pkg::WARM_LIMIT || 36'(d_sel) < ten_step)
                           ? stage_b : stage_a;
                if (aidx_w + CW'(1) >= DEPTH_C)
                begin
                    afull_reg <= 1'b1;
                    aidx_reg  <= '0;
                    cnt_reg   <= DEPTH_C;
                end
                else
                begin
                    aidx_reg <= aidx_w + CW'(1);
                    cnt_reg  <= afull_reg ? DEPTH_C : aidx_w + CW'(1);
                end
            end
            if (cmd.acc_clr)
            begin
                acc_reg <= '0; rd_reg <= '0; rvalid_reg <= 1'b0;
            end
            if (cmd.acc_add)
            begin
                if (rd_reg < cnt_reg)
                    rd_reg <= rd_reg + CW'(1);
                rvalid_reg <= (rd_reg < cnt_reg);
                if (rvalid_reg)
                    acc_reg <= acc_reg + SW'(rdata_reg);
            end
            if (cmd.div_init)
            begin
                rem_reg <= '0; quo_reg <= '0; dcnt_reg <= 6'(SW);
            end
            if (cmd.div_step)
            begin
                acc_reg  <= acc_reg << 1;
                dcnt_reg <= dcnt_reg - 6'd1;
                if (rem_sh >= {1'b0, cnt_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, cnt_reg};
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
            end
            if (cmd.finish)
            begin
                if (cmd.brk)
                begin
                    scnt_reg <= '0; smark_reg <= 1'b0;
                end
                else
                begin
                    logic [4:0] sc;
                    sc = scnt_reg;
                    if (wfs_pkg::distance(out_reg, quo_reg) < 32'(code_step))
                    begin
                        if (sc < wfs_pkg::COUNT_MAX)
                            sc = sc + 5'd1;
                        if (sc > (calibration_mode ? wfs_pkg::CAL_STABLE
                                                   : wfs_pkg::NORM_STABLE))
                            smark_reg <= 1'b1;
                    end
                    else
                        sc = '0;
                    scnt_reg <= sc;
                    out_reg  <= quo_reg;
                end
            end
        end
    end

    assign status.acc_done = cmd.acc_add && !rvalid_reg && (rd_reg >= cnt_reg);
    assign status.div_done = (dcnt_reg == 6'd1);

    assign filtered_value   = out_reg;
    assign first_average    = stage_a;
    assign selected_average = sel_reg;
    assign stable           = smark_reg;

    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> (cnt_reg != '0)) else $error("empty ring divide");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C) else $error("ring count overflow");
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (afull_reg && cmd.acc_clr) |-> (cnt_reg == DEPTH_C)) else $error("full ring count");
endmodule

[sim/testbench.sv]
// Self-checking testbench for the weigh filter with stability detection.
`timescale 1ns / 1ps
module testbench;

    // One expected output beat of the filter.
    typedef struct {
        logic [31:0] filtered;
        logic [31:0] first_avg;
        logic [31:0] selected;
        logic        stable;
        logic        zero_trk;
        logic        load_trk;
    } weigh_result_t;

    // Scoreboard: keeps its own copy of the filter state and predicts each
    // output beat from the accepted input beats.
    class weigh_scoreboard;
        logic [15:0] step_size;
        logic        cal_mode, lin_ok, user_cal, rep_en;
        logic [31:0] last_raw;
        logic [4:0]  warm_a, warm_b;
        logic [31:0] ring_one [16];
        logic [36:0] sum_one;
        logic [3:0]  pos_one;
        logic [31:0] ring_two [16];
        logic [31:0] sum_two;
        logic [3:0]  pos_two;
        logic [31:0] mean_ring [16];
        int          mean_pos;
        logic        mean_full;
        logic [31:0] sel_last, out_last;
        logic [4:0]  close_count;
        logic        hold_mark;
        weigh_result_t pending[$];
        int errors;

        function new();
            step_size = 1; cal_mode = 0; lin_ok = 0; user_cal = 0; rep_en = 0;
            last_raw = 0; warm_a = 0; warm_b = 0; sum_one = 0; pos_one = 0;
            sum_two = 0; pos_two = 0; mean_pos = 0; mean_full = 0;
            sel_last = 0; out_last = 0; close_count = 0; hold_mark = 0;
            errors = 0;
            foreach (ring_one[i])
            begin
                ring_one[i] = 0; ring_two[i] = 0; mean_ring[i] = 0;
            end
        endfunction

        function logic [31:0] gap(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            if (d[31]) d = -d;
            return d;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                wfs_pkg::REG_CODE_STEP: step_size = val;
                wfs_pkg::REG_CAL_MODE:  cal_mode = val[0];
                wfs_pkg::REG_LIN_CAL:   lin_ok = val[0];
                wfs_pkg::REG_USER_CAL:  user_cal = val[0];
                wfs_pkg::REG_REPEAT:    rep_en = val[0];
                default: ;
            endcase
        endfunction

        function void push_result();
            weigh_result_t r;
            r.filtered = out_last;
            r.first_avg = 32'(sum_one >> 8);
            r.selected = sel_last;
            r.stable = hold_mark;
            r.zero_trk = hold_mark;
            r.load_trk = hold_mark & lin_ok & ~user_cal & rep_en;
            pending.push_back(r);
        endfunction

        // Note an accepted input beat and queue its expected output.
        function void note_input(logic brk, logic [31:0] raw);
            logic [31:0] a_val, b_val, sel, res;
            logic [37:0] acc;
            int cnt;
            if (brk)
            begin
                close_count = 0; hold_mark = 0;
                push_result();
                return;
            end
            if (gap(last_raw, raw) > wfs_pkg::JUMP_LIMIT)
            begin
                close_count = 0; hold_mark = 0; warm_a = 0; warm_b = 0;
                mean_pos = 0; mean_full = 0;
            end
            last_raw = raw;
            sum_one = sum_one + raw - ring_one[pos_one];
            ring_one[pos_one] = raw;
            pos_one++;
            a_val = 32'(sum_one >> 8);
            if (warm_a < wfs_pkg::COUNT_MAX) warm_a++;
            if (warm_a > wfs_pkg::WARM_LIMIT)
            begin
                if (warm_b < wfs_pkg::COUNT_MAX) warm_b++;
            end
            else warm_b = 0;
            sum_two = sum_two + a_val - ring_two[pos_two];
            ring_two[pos_two] = a_val;
            pos_two++;
            b_val = sum_two / 16;
            // compare in 33 bits so 10*code_step does not wrap
            if (warm_b > wfs_pkg::WARM_LIMIT ||
                {1'b0, gap(out_last, sel_last)} < 33'(step_size) * 10)
                sel = b_val;
            else
                sel = a_val;
            sel_last = sel;
            mean_ring[mean_pos] = sel;
            mean_pos++;
            if (mean_pos >= 16)
            begin
                mean_full = 1; mean_pos = 0;
            end
            cnt = mean_full ? 16 : mean_pos;
            acc = 0;
            for (int i = 0; i < cnt; i++) acc += mean_ring[i];
            res = 32'(acc / cnt);
            if (gap(out_last, res) < {16'd0, step_size})
            begin
                if (close_count < wfs_pkg::COUNT_MAX) close_count++;
                if (close_count > (cal_mode ? wfs_pkg::CAL_STABLE : wfs_pkg::NORM_STABLE))
                    hold_mark = 1;
            end
            else close_count = 0;
            out_last = res;
            push_result();
        endfunction

        // Check one accepted output beat against the oldest expectation.
        function void check_output(logic [103:0] data);
            weigh_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected output beat %h", $time, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[31:0] !== e.filtered)
            begin
                $display("%0t: filtered_value exp %h got %h", $time, e.filtered, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.first_avg)
            begin
                $display("%0t: first_average exp %h got %h", $time, e.first_avg, data[63:32]);
                errors++;
            end
            if (data[95:64] !== e.selected)
            begin
                $display("%0t: selected_average exp %h got %h", $time, e.selected, data[95:64]);
                errors++;
            end
            if (data[96] !== e.stable)
            begin
                $display("%0t: stable exp %b got %b", $time, e.stable, data[96]);
                errors++;
            end
            if (data[97] !== e.zero_trk)
            begin
                $display("%0t: zero_track exp %b got %b", $time, e.zero_trk, data[97]);
                errors++;
            end
            if (data[98] !== e.load_trk)
            begin
                $display("%0t: load_track exp %b got %b", $time, e.load_trk, data[98]);
                errors++;
            end
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    wire          s_axis_tready;
    logic [31:0]  s_axis_tdata = 0;   // raw_sample[31:0]
    logic         s_axis_tuser = 0;   // action
    wire          m_axis_tvalid;
    logic         m_axis_tready = 0;
    // filtered_value[31:0], first_average[63:32], selected_average[95:64],
    // stable[96], zero_track_enable[97], load_track_enable[98]
    wire [103:0]  m_axis_tdata;
    logic         cfg_valid = 0;
    wire          cfg_ready;
    logic [2:0]   cfg_index = 0;
    logic [15:0]  cfg_data = 0;

    weigh_scoreboard board;
    longint cycles = 0;
    int     sent = 0;
    bit     gaps_on = 1;   // cleared for stretches of back-to-back beats

    localparam longint CYCLE_LIMIT = 2000000;

    always #5 clk = ~clk;

    weigh_filter_with_stability dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Watchdog: end the run if the stream locks up.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Output side: stall at random, check every accepted beat.
    initial
    begin
        int wait_cycles;
        board = new();
        @(posedge rst_n);
        forever
        begin
            wait_cycles = gaps_on ? $urandom_range(0, 17) : 0;
            if (wait_cycles > 0)
            begin
                m_axis_tready <= 0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_axis_tready <= 1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
            board.check_output(m_axis_tdata);
        end
    end

    // Drive one input beat after a random gap while gaps are on; hold until accepted.
    task automatic send_beat(input logic brk, input logic [31:0] raw);
        int wait_cycles;
        wait_cycles = gaps_on ? $urandom_range(0, 17) : 0;
        if (wait_cycles > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (wait_cycles) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= brk;
        s_axis_tdata <= raw;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_input(brk, raw);
        sent++;
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, val);
    endtask

    // Wait until every expected beat is out, then let the datapath settle.
    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_all(input logic [15:0] step, input logic cm, input logic lc,
                           input logic uc, input logic re);
        write_cfg(wfs_pkg::REG_CODE_STEP, step);
        write_cfg(wfs_pkg::REG_CAL_MODE, {15'd0, cm});
        write_cfg(wfs_pkg::REG_LIN_CAL, {15'd0, lc});
        write_cfg(wfs_pkg::REG_USER_CAL, {15'd0, uc});
        write_cfg(wfs_pkg::REG_REPEAT, {15'd0, re});
        cfg_valid <= 0;
    endtask

    // Steady run around a base with random noise up to the given bound and occasional manual breaks.
    task automatic steady_run(input logic [31:0] base, input int len, input int noise);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 60) == 0)
                send_beat(1, $urandom);
            else
                send_beat(0, base + $urandom_range(0, noise));
        end
    endtask

    initial
    begin
        logic [31:0] base;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, jumps, breaks, then a constant run.
        set_all(16'd1, 0, 1, 0, 1);
        send_beat(1, 32'h0);
        send_beat(0, 32'hffffffff);
        send_beat(0, 32'h0);
        send_beat(0, 32'd50000);
        send_beat(0, 32'd0);
        send_beat(0, 32'd50001);
        send_beat(0, 32'h80000000);
        send_beat(0, 32'h7fffffff);
        send_beat(1, 32'hffffffff);
        for (int i = 0; i < 16; i++) send_beat(0, 32'd1000);
        drain();

        // Random phases; each sets one of four register settings, the fourth drawn at random.
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: set_all(16'hffff, 1, 1, 0, 1);
                1: set_all(16'd1, 0, 1, 1, 1);
                2: set_all(16'd0, 0, 0, 0, 0);
                default: set_all(16'($urandom_range(1, 2000)), 1'($urandom),
                                 1'($urandom), 1'($urandom), 1'($urandom));
            endcase
            gaps_on = (ph % 3) != 2;
            repeat (5)
            begin
                base = $urandom;
                if ($urandom_range(0, 3) == 0)
                    steady_run(base, 8, 32'hffffffff);     // noise, jumps
                else
                    steady_run(base, 31, $urandom_range(0, 300));
            end
            drain();
        end

        $display("covered %0d input beats over 13 register settings,", sent);
        $display("including raw jumps, manual breaks, warm-up and stable runs");
        if (board.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

[sim.f]
rtl/core/wfs_pkg.sv
rtl/core/wfs_ctrl.sv
rtl/core/wfs_datapath.sv
rtl/core/weigh_filter_with_stability.sv
sim/testbench.sv
